### rtl/core/tblt_pkg.sv
// Shared types, constants and codes for the translated-block lookup table.
package tblt_pkg;

    localparam int THUMB_DEPTH = 4096;
    localparam int ARM_DEPTH   = 16384;
    localparam int THUMB_AW    = (THUMB_DEPTH > 2) ? $clog2(THUMB_DEPTH) : 1;
    localparam int ARM_AW      = (ARM_DEPTH > 2) ? $clog2(ARM_DEPTH) : 1;
    localparam int CLR_DEPTH   = (ARM_DEPTH > THUMB_DEPTH) ? ARM_DEPTH : THUMB_DEPTH;
    localparam int CLR_AW      = (CLR_DEPTH > 2) ? $clog2(CLR_DEPTH) : 1;
    localparam int ENT_W       = 34;
    localparam int TAG_W       = 33;

    localparam logic [31:0] HASH_MUL = 32'd2654435761;
    localparam logic [THUMB_AW-1:0] HASH_LO = HASH_MUL[THUMB_AW-1:0];

    // entry layout
    localparam int ENT_VALID = 33;
    localparam int ENT_HOOK  = 32;

    // operations
    localparam logic [1:0] OP_PLACE  = 2'd0;
    localparam logic [1:0] OP_STATIC = 2'd1;
    localparam logic [1:0] OP_DYNAMIC = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NONE  = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_MIDIT = 3'd4;
    localparam logic [2:0] ST_THUNK = 3'd5;

    // config register indexes
    localparam logic [1:0] CFG_ARM_COUNT  = 2'd0;
    localparam logic [1:0] CFG_THUNK_BASE = 2'd1;

    // entry update modes
    localparam logic [1:0] MODE_PLACE  = 2'd0;
    localparam logic [1:0] MODE_HOOK   = 2'd1;
    localparam logic [1:0] MODE_UNHOOK = 2'd2;

    // result sources
    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_ENT  = 2'd1;
    localparam logic [1:0] RES_LOOK = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] guest_address;
        logic        thumb_mode;
        logic [31:0] block_handle;
        logic        hook_enable;
        logic        in_it_block;
    } tblt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        hooked;
        logic        block_found;
        logic [31:0] found_handle;
    } tblt_out_t;

    typedef struct packed {
        logic       clr_wr;
        logic       ld_in;
        logic       ld_tgt;
        logic       tgt_old;
        logic       hash;
        logic       probe_rd;
        logic       probe_next;
        logic       arm_rd;
        logic       ent_wr;
        logic [1:0] ent_mode;
        logic       tag_wr;
        logic       dyn_clear;
        logic       dyn_set;
        logic       res_ld;
        logic [1:0] res_kind;
        logic [2:0] res_status;
        logic       out_ld;
    } tblt_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       thunk_hit;
        logic       it_hit;
        logic       dyn_active;
        logic       enable;
        logic       tgt_thumb;
        logic       arm_ok;
        logic       tag_hit;
        logic       probe_last;
        logic       ent_hook;
        logic       clr_done;
        logic       out_free;
    } tblt_sts_t;

endpackage

### rtl/core/translated_block_lookup_table.sv
// Top level of the translated-block lookup table.
// Maps guest code addresses to translated-block handles. A32 addresses go to a
// direct-mapped store indexed by address/4 (limited by arm_entry_count); Thumb
// addresses go to an open-addressed store: multiplicative hash of address/2,
// then linear probing, one slot at a time (tag and entry read together from
// registered-read RAMs, compared the next cycle). A dynamic-hook move that
// first removes the old hook takes both walks back to back. After reset the
// block runs a clearing pass over the larger store's depth (16384 entries),
// accepting no request meanwhile; configuration writes are always taken.
// One request is worked at a time; a finished result waits in the output
// register while the next request is accepted.
module translated_block_lookup_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tblt_pkg::tblt_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tblt_pkg::tblt_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import tblt_pkg::*;

    tblt_cmd_t cmd;
    tblt_sts_t sts;

    // config registers are written whenever asked
    assign cfg_ready = 1'b1;

    tblt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tblt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/core/tblt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tblt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/tblt_datapath.sv
// Datapath: config registers, stores, hash, probe counter, result registers.
module tblt_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  tblt_pkg::tblt_in_t  s_data,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                m_ready,
    output logic                m_valid,
    output tblt_pkg::tblt_out_t m_data,
    input  tblt_pkg::tblt_cmd_t cmd,
    output tblt_pkg::tblt_sts_t sts
);
    import tblt_pkg::*;

    logic [14:0]         arm_count_reg;
    logic [31:0]         thunk_reg;
    tblt_in_t            in_reg;
    logic [31:0]         tgt_addr_reg;
    logic                tgt_thumb_reg;
    logic [THUMB_AW-1:0] slot_reg;
    logic [THUMB_AW-1:0] cnt_reg;
    logic [CLR_AW-1:0]   clr_cnt_reg;
    logic [31:0]         dyn_addr_reg;
    logic                dyn_act_reg;
    logic [ENT_W-1:0]    res_ent_reg;
    logic [2:0]          res_status_reg;
    logic                m_valid_reg;
    tblt_out_t           m_data_reg;

    logic [THUMB_AW-1:0] hash_slot;
    logic [29:0]         arm_idx;
    logic [ARM_AW-1:0]   arm_addr;
    logic [TAG_W-1:0]    tag_rdata;
    logic [ENT_W-1:0]    tent_rdata;
    logic [ENT_W-1:0]    aent_rdata;
    logic [ENT_W-1:0]    ent_cur;
    logic [ENT_W-1:0]    ent_new;
    logic [ENT_W-1:0]    res_ent;
    logic                tag_exact;
    logic                arm_we;
    logic [ARM_AW-1:0]   arm_waddr;
    logic [ENT_W-1:0]    ent_wdata;
    logic                thumb_we;
    logic                tag_we;
    logic [THUMB_AW-1:0] thumb_waddr;
    logic [TAG_W-1:0]    tag_wdata;
    logic                clr_arm;
    logic                clr_thumb;

    assign hash_slot = THUMB_AW'(tgt_addr_reg[THUMB_AW:1] * HASH_LO);
    assign arm_idx   = tgt_addr_reg[31:2];
    assign arm_addr  = arm_idx[ARM_AW-1:0];
    assign ent_cur   = tgt_thumb_reg ? tent_rdata : aent_rdata;
    assign tag_exact = tag_rdata[32] && (tag_rdata[31:0] == tgt_addr_reg);

    always_comb begin
        case (cmd.ent_mode)
            MODE_PLACE:  ent_new = {1'b1, ent_cur[ENT_HOOK], in_reg.block_handle};
            MODE_HOOK:   ent_new = ent_cur | (ENT_W'(1) << ENT_HOOK);
            MODE_UNHOOK: ent_new = ent_cur & ~(ENT_W'(1) << ENT_HOOK);
            default:     ent_new = ent_cur;
        endcase
    end

    // clearing pass covers both stores
    assign clr_arm   = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(ARM_DEPTH));
    assign clr_thumb = ({1'b0, clr_cnt_reg} < (CLR_AW + 1)'(THUMB_DEPTH));

    always_comb begin
        arm_we      = 1'b0;
        thumb_we    = 1'b0;
        tag_we      = 1'b0;
        arm_waddr   = arm_addr;
        thumb_waddr = slot_reg;
        ent_wdata   = ent_new;
        tag_wdata   = {1'b1, tgt_addr_reg};
        if (cmd.clr_wr) begin
            arm_we      = clr_arm;
            thumb_we    = clr_thumb;
            tag_we      = clr_thumb;
            arm_waddr   = clr_cnt_reg[ARM_AW-1:0];
            thumb_waddr = clr_cnt_reg[THUMB_AW-1:0];
            ent_wdata   = '0;
            tag_wdata   = '0;
        end else begin
            arm_we   = cmd.ent_wr && !tgt_thumb_reg;
            thumb_we = cmd.ent_wr && tgt_thumb_reg;
            tag_we   = cmd.tag_wr;
        end
    end

    tblt_ram #(.WIDTH(ENT_W), .DEPTH(ARM_DEPTH)) u_arm_ram (
        .aclk  (aclk),
        .we    (arm_we),
        .waddr (arm_waddr),
        .wdata (ent_wdata),
        .re    (cmd.arm_rd),
        .raddr (arm_addr),
        .rdata (aent_rdata)
    );

    tblt_ram #(.WIDTH(TAG_W), .DEPTH(THUMB_DEPTH)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (thumb_waddr),
        .wdata (tag_wdata),
        .re    (cmd.probe_rd),
        .raddr (slot_reg),
        .rdata (tag_rdata)
    );

    tblt_ram #(.WIDTH(ENT_W), .DEPTH(THUMB_DEPTH)) u_thumb_ram (
        .aclk  (aclk),
        .we    (thumb_we),
        .waddr (thumb_waddr),
        .wdata (ent_wdata),
        .re    (cmd.probe_rd),
        .raddr (slot_reg),
        .rdata (tent_rdata)
    );

    always_comb begin
        case (cmd.res_kind)
            RES_ENT:  res_ent = ent_new;
            RES_LOOK: res_ent = (!tgt_thumb_reg || tag_exact) ? ent_cur : '0;
            default:  res_ent = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_count_reg <= '0;
            thunk_reg     <= '1;
            dyn_addr_reg  <= '0;
            dyn_act_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ARM_COUNT:  arm_count_reg <= cfg_data[14:0];
                    CFG_THUNK_BASE: thunk_reg     <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.dyn_clear) begin
                dyn_act_reg <= 1'b0;
            end
            if (cmd.dyn_set) begin
                dyn_act_reg  <= 1'b1;
                dyn_addr_reg <= in_reg.guest_address;
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_in) begin
            in_reg <= s_data;
        end
        if (cmd.ld_tgt) begin
            if (cmd.tgt_old) begin
                tgt_addr_reg  <= {dyn_addr_reg[31:1], 1'b0};
                tgt_thumb_reg <= dyn_addr_reg[0];
            end else if (in_reg.operation == OP_PLACE || in_reg.operation == OP_LOOKUP) begin
                tgt_addr_reg  <= in_reg.guest_address;
                tgt_thumb_reg <= in_reg.thumb_mode;
            end else begin
                tgt_addr_reg  <= {in_reg.guest_address[31:1], 1'b0};
                tgt_thumb_reg <= in_reg.guest_address[0];
            end
        end
        if (cmd.hash) begin
            slot_reg <= hash_slot;
            cnt_reg  <= '0;
        end else if (cmd.probe_next) begin
            slot_reg <= slot_reg + 1'b1;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.res_ld) begin
            res_ent_reg <= res_ent;
            if (cmd.res_kind == RES_LOOK) begin
                res_status_reg <= res_ent[ENT_VALID] ? ST_OK : ST_NONE;
            end else begin
                res_status_reg <= cmd.res_status;
            end
        end
        if (cmd.out_ld) begin
            m_data_reg.status       <= res_status_reg;
            m_data_reg.hooked       <= res_ent_reg[ENT_HOOK];
            m_data_reg.block_found  <= res_ent_reg[ENT_VALID];
            m_data_reg.found_handle <= res_ent_reg[ENT_VALID] ? res_ent_reg[31:0] : 32'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.op         = in_reg.operation;
    assign sts.thunk_hit  = in_reg.guest_address >= thunk_reg;
    assign sts.it_hit     = in_reg.thumb_mode && in_reg.in_it_block;
    assign sts.dyn_active = dyn_act_reg;
    assign sts.enable     = in_reg.hook_enable;
    assign sts.tgt_thumb  = tgt_thumb_reg;
    assign sts.arm_ok     = (arm_idx < {15'd0, arm_count_reg}) && (arm_idx < 30'(ARM_DEPTH));
    assign sts.tag_hit    = !tag_rdata[32] || (tag_rdata[31:0] == tgt_addr_reg);
    assign sts.probe_last = cnt_reg == THUMB_AW'(THUMB_DEPTH - 1);
    assign sts.ent_hook   = ent_cur[ENT_HOOK];
    assign sts.clr_done   = clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1);
    assign sts.out_free   = !m_valid_reg || m_ready;

endmodule

### rtl/core/tblt_ctrl.sv
// Controller: sequences each request through decode, probe, update and result.
module tblt_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tblt_pkg::tblt_sts_t sts,
    output tblt_pkg::tblt_cmd_t cmd
);
    import tblt_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_ROUTE  = 4'd3;
    localparam logic [3:0] S_PROBE  = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_ENT    = 4'd6;
    localparam logic [3:0] S_AFTER  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       old_reg, old_next;   // working on the previous dynamic hook
    logic       hit;
    logic [1:0] mode;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        if (old_reg) begin
            mode = MODE_UNHOOK;
        end else if (sts.op == OP_PLACE) begin
            mode = MODE_PLACE;
        end else begin
            mode = MODE_HOOK;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        old_next   = old_reg;
        hit        = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                old_next = 1'b0;
                if (sts.op == OP_LOOKUP && sts.thunk_hit) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_THUNK;
                    state_next     = S_OUT;
                end else if (sts.op == OP_LOOKUP && sts.it_hit) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_MIDIT;
                    state_next     = S_OUT;
                end else if (sts.op == OP_DYNAMIC && sts.dyn_active) begin
                    cmd.ld_tgt    = 1'b1;
                    cmd.tgt_old   = 1'b1;
                    cmd.dyn_clear = 1'b1;
                    old_next      = 1'b1;
                    state_next    = S_ROUTE;
                end else if (sts.op == OP_DYNAMIC && !sts.enable) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_OUT;
                end else begin
                    cmd.ld_tgt = 1'b1;
                    state_next = S_ROUTE;
                end
            end
            S_ROUTE: begin
                if (sts.tgt_thumb) begin
                    cmd.hash   = 1'b1;
                    state_next = S_PROBE;
                end else if (sts.arm_ok) begin
                    cmd.arm_rd = 1'b1;
                    state_next = S_ENT;
                end else if (old_reg) begin
                    state_next = S_AFTER;
                end else begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_RANGE;
                    state_next     = S_OUT;
                end
            end
            S_PROBE: begin
                cmd.probe_rd = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK, S_ENT: begin
                hit = (state_reg == S_ENT) || sts.tag_hit;
                if (hit && sts.op == OP_LOOKUP) begin
                    cmd.res_ld   = 1'b1;
                    cmd.res_kind = RES_LOOK;
                    state_next   = S_OUT;
                end else if (hit) begin
                    cmd.ent_wr   = 1'b1;
                    cmd.ent_mode = mode;
                    cmd.tag_wr   = (state_reg == S_CHECK);
                    if (old_reg) begin
                        state_next = S_AFTER;
                    end else begin
                        cmd.dyn_set  = (sts.op == OP_DYNAMIC) && !sts.ent_hook;
                        cmd.res_ld   = 1'b1;
                        cmd.res_kind = RES_ENT;
                        state_next   = S_OUT;
                    end
                end else if (!sts.probe_last) begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_PROBE;
                end else if (sts.op == OP_LOOKUP) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_NONE;
                    state_next     = S_OUT;
                end else if (old_reg) begin
                    state_next = S_AFTER;
                end else begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_OUT;
                end
            end
            S_AFTER: begin
                old_next = 1'b0;
                if (!sts.enable) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_OUT;
                end else begin
                    cmd.ld_tgt = 1'b1;
                    state_next = S_ROUTE;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            old_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            old_reg   <= old_next;
        end
    end

`ifndef SYNTH
    a_dyn_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.dyn_set && cmd.dyn_clear))
        else $error("dynamic hook set and cleared together");
    a_clear_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_wr |-> !(cmd.ent_wr || cmd.tag_wr || s_ready))
        else $error("store update during clearing pass");
    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECIDE))
        else $error("accepted request not decoded");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> sts.out_free)
        else $error("result overwrites pending result");
`endif

endmodule
